### design/seg_scan_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment scan serializer package
// Shared types, operation codes and the character font used by the
// serializer and its checker, and the decimal conversion of the serializer.
// ----------------------------------------------------------------------------
package seg_scan_pkg;

    // Operation codes carried in the request.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LED     = 2'd1;
    localparam logic [1:0] OP_CHARS   = 2'd2;
    localparam logic [1:0] OP_DECIMAL = 2'd3;

    // Display geometry and frame shape.
    localparam int         DIGIT_COUNT = 4;
    localparam int         FRAME_BITS  = 16;
    localparam logic [3:0] LAST_BIT    = 4'(FRAME_BITS - 1);

    // Font constants.
    localparam logic [7:0] FONT_FIRST      = 8'd32;
    localparam logic [7:0] FONT_LAST       = 8'd96;
    localparam logic [6:0] FONT_DIGIT_BASE = 7'd16;
    localparam logic [7:0] BLANK_GLYPH     = 8'hff;
    localparam logic [15:0] DEC_MAX        = 16'd9999;

    // Weights of the three upper decimal digits.
    localparam logic [13:0] DEC_WEIGHT [0:2] = '{14'd1000, 14'd100, 14'd10};

    // Active-low glyphs for ASCII codes 32 through 96.
    localparam logic [7:0] FONT_GLYPHS [0:64] = '{
        8'hff, 8'h79, 8'hdd, 8'h9d, 8'h93, 8'had, 8'he3, 8'hfd,
        8'hc6, 8'hf0, 8'h9c, 8'hb9, 8'h7f, 8'hbf, 8'h7f, 8'had,
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90,
        8'h00, 8'h00, 8'h00, 8'hb7, 8'h00, 8'h3c, 8'h30,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hc3, 8'h89,
        8'hcf, 8'he1, 8'h8a, 8'hc7, 8'h8d, 8'hab, 8'hc0, 8'h8c,
        8'h98, 8'haf, 8'h92, 8'h87, 8'hc1, 8'he1, 8'hff, 8'hb6,
        8'h91, 8'hb7,
        8'ha7, 8'h9b, 8'hb3, 8'hfe, 8'hf7, 8'h9f
    };

    // One request.
    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  led_index;
        logic        led_on;
        logic [7:0]  char_first;
        logic [7:0]  char_second;
        logic [7:0]  char_third;
        logic [7:0]  char_fourth;
        logic [15:0] decimal_value;
    } t_item;

    // One serial result.
    typedef struct packed {
        logic       serial_bit;
        logic       latch_after;
        logic [1:0] scanned_digit;
    } t_result;

    // Maps an ASCII code to its glyph; codes outside the font show blank.
    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        logic [7:0] offset;
        offset = code - FONT_FIRST;
        if ((code < FONT_FIRST) || (code > FONT_LAST)) begin
            return BLANK_GLYPH;
        end
        return FONT_GLYPHS[offset[6:0]];
    endfunction

    // Converts a value to four glyphs, leftmost in the top byte. The value
    // saturates at 9999 and leading zeros show blank, but the units digit
    // always shows. Each upper digit comes from compares and one subtraction.
    function automatic logic [31:0] dec_glyphs(input logic [15:0] value);
        logic [13:0] n;
        logic [13:0] rem;
        logic [3:0]  dig [0:3];
        logic        lead;
        logic [31:0] res;
        n    = (value > DEC_MAX) ? DEC_MAX[13:0] : value[13:0];
        rem  = n;
        lead = 1'b1;
        res  = '0;
        for (int i = 0; i < 3; i++) begin
            dig[i] = 4'd0;
            for (int k = 1; k < 10; k++) begin
                if (rem >= 14'(k * DEC_WEIGHT[i])) begin
                    dig[i] = 4'(k);
                end
            end
            rem = rem - 14'(dig[i] * DEC_WEIGHT[i]);
        end
        dig[3] = rem[3:0];
        for (int i = 0; i < 4; i++) begin
            if ((i < 3) && lead && (dig[i] == 4'd0)) begin
                res[8*(3-i) +: 8] = BLANK_GLYPH;
            end else begin
                lead = 1'b0;
                res[8*(3-i) +: 8] = FONT_GLYPHS[FONT_DIGIT_BASE + {3'b000, dig[i]}];
            end
        end
        return res;
    endfunction

endpackage

### design/seven_segment_scan_serializer_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment scan serializer
// Holds four segment bytes, eight LED bits and a scan digit, and turns each
// scan tick into a sixteen-bit serial frame for two chained shift registers.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid, o_stall, i_item) carries one operation per
// request: scan tick, LED set, four-character write or decimal write. The
// result channel (o_valid, i_stall, o_result) carries one serial bit per
// transfer, MSB first: the inverted control byte, then the segment byte of
// the scanned digit. latch_after marks the sixteenth bit of a frame.
// A request is registered at acceptance and executed in the next cycle,
// unless it is a tick that must wait for the shifter. LED, character
// and decimal writes complete when executed, so they flow at one per
// cycle while no tick waits ahead. A tick loads the output shifter and
// its first bit is offered the cycle after; the frame then takes sixteen
// result transfers. A tick waits in the request register while a frame is
// still shifting; the next frame loads on the cycle the last bit is taken.
// When the receiver stalls, the current bit holds and the shifter waits.
// Reset clears the segment store, LED bits, scan digit and both valids.
// ----------------------------------------------------------------------------
module seven_segment_scan_serializer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  seg_scan_pkg::t_item   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output seg_scan_pkg::t_result o_result
);

    // Request register.
    logic                r_in_valid;
    seg_scan_pkg::t_item r_in;

    // Display state.
    logic [7:0] r_seg [0:3];
    logic [7:0] r_led;
    logic [1:0] r_scan;

    // Output shifter.
    logic        r_busy;
    logic [15:0] r_frame;
    logic [3:0]  r_cnt;
    logic [1:0]  r_digit;

    logic        w_in_accept;
    logic        w_out_accept;
    logic        w_last_taken;
    logic        w_load_ok;
    logic        w_is_tick;
    logic        w_consume;
    logic        w_load;
    logic [7:0]  w_mask;
    logic [7:0]  w_control;
    logic [31:0] w_dec;
    logic [1:0]  n_scan;

    // Handshake decisions.
    assign w_in_accept  = i_valid && !o_stall;
    assign w_out_accept = r_busy && !i_stall;
    assign w_last_taken = w_out_accept && (r_cnt == seg_scan_pkg::LAST_BIT);
    assign w_load_ok    = !r_busy || w_last_taken;
    assign w_is_tick    = (r_in.operation == seg_scan_pkg::OP_TICK);
    assign w_consume    = r_in_valid && (!w_is_tick || w_load_ok);
    assign w_load       = r_in_valid && w_is_tick && w_load_ok;
    assign o_stall      = r_in_valid && !w_consume;

    // Frame contents and operation data.
    assign w_mask    = 8'(1) << r_in.led_index;
    assign w_control = ~((8'(1) << r_scan) | r_led);
    assign w_dec     = seg_scan_pkg::dec_glyphs(r_in.decimal_value);
    assign n_scan    = ({1'b0, r_scan} + 3'd1 >= 3'(seg_scan_pkg::DIGIT_COUNT))
                       ? 2'd0 : r_scan + 2'd1;

    // Result fields come straight from the shifter.
    assign o_valid                = r_busy;
    assign o_result.serial_bit    = r_frame[15];
    assign o_result.latch_after   = (r_cnt == seg_scan_pkg::LAST_BIT);
    assign o_result.scanned_digit = r_digit;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_accept) begin
            r_in <= i_item;
        end
    end

    // Display state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg[0] <= '0;
            r_seg[1] <= '0;
            r_seg[2] <= '0;
            r_seg[3] <= '0;
            r_led    <= '0;
            r_scan   <= '0;
        end else if (w_consume) begin
            case (r_in.operation)
                seg_scan_pkg::OP_LED: begin
                    r_led <= r_in.led_on ? (r_led | w_mask) : (r_led & ~w_mask);
                end
                seg_scan_pkg::OP_CHARS: begin
                    r_seg[0] <= seg_scan_pkg::glyph_of(r_in.char_first);
                    r_seg[1] <= seg_scan_pkg::glyph_of(r_in.char_second);
                    r_seg[2] <= seg_scan_pkg::glyph_of(r_in.char_third);
                    r_seg[3] <= seg_scan_pkg::glyph_of(r_in.char_fourth);
                end
                seg_scan_pkg::OP_DECIMAL: begin
                    r_seg[0] <= w_dec[31:24];
                    r_seg[1] <= w_dec[23:16];
                    r_seg[2] <= w_dec[15:8];
                    r_seg[3] <= w_dec[7:0];
                end
                default: begin
                    r_scan <= n_scan;
                end
            endcase
        end
    end

    // Output shifter: loads a frame on a tick, shifts on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_last_taken) begin
            r_busy <= 1'b0;
        end else if (w_out_accept) begin
            r_cnt <= r_cnt + 4'd1;
        end
        if (w_load) begin
            r_frame <= {w_control, r_seg[r_scan]};
            r_digit <= r_scan;
        end else if (w_out_accept) begin
            r_frame <= {r_frame[14:0], 1'b0};
        end
    end

endmodule

### design/seg_scan_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment scan serializer checker
// Port-level checks on the serializer's channels, bound into the serializer.
// ----------------------------------------------------------------------------
module seg_scan_assertions (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input seg_scan_pkg::t_item   i_item,
    input logic                  o_valid,
    input logic                  i_stall,
    input seg_scan_pkg::t_result o_result
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped under stall");

    // A stalled result keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("result payload changed under stall");

    // Within a frame the next bit follows at once and for the same digit.
    a_frame_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_result.latch_after
        |=> o_valid && $stable(o_result.scanned_digit))
        else $error("frame broke before its last bit");

    // After reset no result is offered and requests are not stalled.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not idle after reset");

endmodule

bind seven_segment_scan_serializer_unit seg_scan_assertions u_seg_scan_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);

### tb/seg_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan serializer checker
// Watches the request and result channels of the serializer and keeps its
// own copy of the segment store, LED bits and scan digit. Every accepted
// tick request queues the sixteen serial bits that the frame should carry.
// Every accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module seg_scan_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  seg_scan_pkg::t_item   i_req_item,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  seg_scan_pkg::t_result i_res_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Shadow of the display state.
    logic [7:0] segment_copy [0:3];
    logic [7:0] led_copy;
    logic [1:0] scan_copy;

    // Serial bits still owed by the block, oldest first.
    seg_scan_pkg::t_result expected_bits [$];
    int      fail_count  = 0;
    int      bits_checked = 0;

    assign o_fail_count = fail_count;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", bits_checked, msg);
        fail_count++;
    endtask

    // Glyph for one character; anything outside the font is blank.
    function automatic logic [7:0] font_lookup(input logic [7:0] code);
        if ((code < seg_scan_pkg::FONT_FIRST) || (code > seg_scan_pkg::FONT_LAST)) begin
            return seg_scan_pkg::BLANK_GLYPH;
        end
        return seg_scan_pkg::FONT_GLYPHS[int'(code) - int'(seg_scan_pkg::FONT_FIRST)];
    endfunction

    // Writes a saturated decimal value with leading blanks into the store.
    task automatic decimal_to_segments(input logic [15:0] value);
        int n;
        int blanks;
        int digits [4];
        n = (value > seg_scan_pkg::DEC_MAX) ? int'(seg_scan_pkg::DEC_MAX) : int'(value);
        digits[0] = n / 1000;
        digits[1] = (n % 1000) / 100;
        digits[2] = (n % 100) / 10;
        digits[3] = n % 10;
        if (n < 10) begin
            blanks = 3;
        end else if (n < 100) begin
            blanks = 2;
        end else if (n < 1000) begin
            blanks = 1;
        end else begin
            blanks = 0;
        end
        for (int i = 0; i < 4; i++) begin
            segment_copy[i] = (i < blanks) ? seg_scan_pkg::BLANK_GLYPH
                : seg_scan_pkg::FONT_GLYPHS[int'(seg_scan_pkg::FONT_DIGIT_BASE) + digits[i]];
        end
    endtask

    // Applies one accepted request and queues the bits of a tick frame.
    task automatic predict_request(input seg_scan_pkg::t_item req);
        logic [15:0]           frame;
        logic [1:0]            digit;
        seg_scan_pkg::t_result bit_res;
        case (req.operation)
            seg_scan_pkg::OP_LED: begin
                led_copy[req.led_index] = req.led_on;
            end
            seg_scan_pkg::OP_CHARS: begin
                segment_copy[0] = font_lookup(req.char_first);
                segment_copy[1] = font_lookup(req.char_second);
                segment_copy[2] = font_lookup(req.char_third);
                segment_copy[3] = font_lookup(req.char_fourth);
            end
            seg_scan_pkg::OP_DECIMAL: begin
                decimal_to_segments(req.decimal_value);
            end
            seg_scan_pkg::OP_TICK: begin
                digit = scan_copy;
                frame = {~((8'd1 << digit) | led_copy), segment_copy[digit]};
                // The frame leaves MSB first; the last bit carries the latch mark.
                for (int k = seg_scan_pkg::FRAME_BITS - 1; k >= 0; k--) begin
                    bit_res.serial_bit    = frame[k];
                    bit_res.latch_after   = (k == 0);
                    bit_res.scanned_digit = digit;
                    expected_bits.push_back(bit_res);
                end
                scan_copy = ((int'(digit) + 1) >= seg_scan_pkg::DIGIT_COUNT)
                            ? 2'd0 : digit + 2'd1;
            end
            default: begin
            end
        endcase
    endtask

    // Compares one accepted result with the oldest expected bit.
    task automatic check_result(input seg_scan_pkg::t_result got);
        seg_scan_pkg::t_result want;
        if (expected_bits.size() == 0) begin
            report_mismatch($sformatf("serial bit %b with nothing expected", got.serial_bit));
        end else begin
            want = expected_bits.pop_front();
            if (got.serial_bit !== want.serial_bit) begin
                report_mismatch($sformatf("serial_bit %b, expected %b",
                                          got.serial_bit, want.serial_bit));
            end
            if (got.latch_after !== want.latch_after) begin
                report_mismatch($sformatf("latch_after %b, expected %b",
                                          got.latch_after, want.latch_after));
            end
            if (got.scanned_digit !== want.scanned_digit) begin
                report_mismatch($sformatf("scanned_digit %0d, expected %0d",
                                          got.scanned_digit, want.scanned_digit));
            end
        end
        bits_checked++;
    endtask

    // Results are checked before the request of the same edge is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                segment_copy[i] = 8'h00;
            end
            led_copy  = 8'h00;
            scan_copy = 2'd0;
            expected_bits.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                check_result(i_res_result);
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req_item);
            end
        end
        o_pending <= expected_bits.size();
    end

endmodule

### tb/tb_seven_segment_scan_serializer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan serializer testbench
// Drives directed and random requests (ticks, LED sets, character and
// decimal writes) in bursts with random gaps, while the receiver stalls on
// changing patterns. A checker beside the block predicts every serial bit.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_serializer_unit;

    localparam int RANDOM_ITEMS   = 405;
    localparam int HOLD_AT        = 100;
    localparam int PAUSE_AT       = 250;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RUN_LIMIT_NS   = 2_000_000;

    // Receiver stall patterns.
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    seg_scan_pkg::t_item   i_item  = '0;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    seg_scan_pkg::t_result o_result;

    int fail_count;
    int pending_bits;

    // Long receiver hold-offs asked for and served.
    int hold_requests = 0;
    int hold_served   = 0;

    // Requests left in the current sender burst.
    int burst_left = 0;

    seven_segment_scan_serializer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    seg_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req_item   (i_item),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_result (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_bits)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Random content in every field, so unused fields toggle too.
    function automatic seg_scan_pkg::t_item random_bits();
        logic [63:0]         raw;
        seg_scan_pkg::t_item req;
        raw = {$urandom, $urandom};
        req = raw[$bits(seg_scan_pkg::t_item)-1:0];
        return req;
    endfunction

    function automatic seg_scan_pkg::t_item tick_request();
        seg_scan_pkg::t_item req;
        req = random_bits();
        req.operation = seg_scan_pkg::OP_TICK;
        return req;
    endfunction

    function automatic seg_scan_pkg::t_item led_request(input logic [2:0] index,
                                                        input logic on);
        seg_scan_pkg::t_item req;
        req = random_bits();
        req.operation = seg_scan_pkg::OP_LED;
        req.led_index = index;
        req.led_on    = on;
        return req;
    endfunction

    function automatic seg_scan_pkg::t_item chars_request(input logic [7:0] c0,
                                                          input logic [7:0] c1,
                                                          input logic [7:0] c2,
                                                          input logic [7:0] c3);
        seg_scan_pkg::t_item req;
        req = random_bits();
        req.operation   = seg_scan_pkg::OP_CHARS;
        req.char_first  = c0;
        req.char_second = c1;
        req.char_third  = c2;
        req.char_fourth = c3;
        return req;
    endfunction

    function automatic seg_scan_pkg::t_item decimal_request(input logic [15:0] value);
        seg_scan_pkg::t_item req;
        req = random_bits();
        req.operation     = seg_scan_pkg::OP_DECIMAL;
        req.decimal_value = value;
        return req;
    endfunction

    // Mostly printable characters, sometimes any byte.
    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 3) != 0) begin
            return 8'($urandom_range(seg_scan_pkg::FONT_FIRST, seg_scan_pkg::FONT_LAST));
        end
        return 8'($urandom);
    endfunction

    // Spreads decimal values over every digit count and the saturation edge.
    function automatic logic [15:0] random_decimal();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 9));
            1:       return 16'($urandom_range(10, 99));
            2:       return 16'($urandom_range(100, 999));
            3:       return 16'($urandom_range(1000, 9999));
            4:       return 16'($urandom_range(9990, 10010));
            default: return 16'($urandom);
        endcase
    endfunction

    // Ticks dominate so that frames keep the output side busy.
    function automatic seg_scan_pkg::t_item random_request();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return tick_request();
        end else if (pick < 6) begin
            return led_request(3'($urandom), 1'($urandom));
        end else if (pick < 8) begin
            return chars_request(random_char(), random_char(), random_char(), random_char());
        end
        return decimal_request(random_decimal());
    endfunction

    // Offers one request until accepted, then maybe opens a gap.
    task automatic send_request(input seg_scan_pkg::t_item req);
        int gap;
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: changing stall patterns, plus long hold-offs on request.
    initial begin : receiver
        int       hold_left;
        int       pattern_left;
        int       phase;
        t_rx_mode mode;
        hold_left    = 0;
        pattern_left = 0;
        phase        = 0;
        mode         = RX_FREE;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (pattern_left == 0) begin
                mode         = t_rx_mode'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 200);
            end else begin
                pattern_left--;
            end
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FREE:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 1) == 1);
                    default:  i_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset frame, LED limits, font limits, decimal limits.
        send_request(tick_request());
        send_request(led_request(3'd0, 1'b1));
        send_request(led_request(3'd7, 1'b1));
        send_request(led_request(3'd3, 1'b0));
        send_request(chars_request(8'd32, 8'd96, 8'd31, 8'd255));
        repeat (4) send_request(tick_request());
        send_request(chars_request(8'd0, 8'd97, 8'd65, 8'd48));
        send_request(decimal_request(16'd0));
        send_request(tick_request());
        send_request(decimal_request(16'd9));
        send_request(decimal_request(16'd10));
        send_request(decimal_request(16'd99));
        send_request(decimal_request(16'd100));
        send_request(decimal_request(16'd999));
        send_request(tick_request());
        send_request(decimal_request(16'd1000));
        send_request(decimal_request(16'd9999));
        send_request(tick_request());
        send_request(decimal_request(16'd10000));
        send_request(decimal_request(16'hffff));
        send_request(tick_request());
        send_request(led_request(3'd0, 1'b0));

        // Random part.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                // The receiver holds off while ticks keep coming, so the
                // block fills and stalls its request side.
                hold_requests++;
                repeat (6) send_request(tick_request());
            end
            if (n == PAUSE_AT) begin
                // The sender waits for every owed bit before going on.
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending_bits == 0);
                @(posedge i_clk);
            end
            send_request(random_request());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_bits == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if ((fail_count == 0) && (pending_bits == 0)) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
